>>> hw/rtl/all_pkg.sv
// shared types and constants for the array linked list engine
// no dependencies
package all_pkg;

    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_POS  = 3'd5,
        OP_SEARCH   = 3'd6,
        OP_READOUT  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_RANGE = 3'd3,
        ST_NFND  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DECIDE,
        S_RDCUR,
        S_WALK,
        S_LINK,
        S_EMIT,
        S_ROUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    init_step;   // write reset link for init index
        logic    load;        // capture request
        logic    rd_cur;      // read value and link at cur
        logic    advance;     // prev <= cur, cur <= next, count++
        logic    do_update;   // apply the op's link changes
        logic    set_res;     // capture a result
        status_t res_status;
        logic    res_value;   // result carries value read
        logic    res_fpos;    // result carries count
        logic    res_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic list_empty;
        logic pool_full;
        logic cur_nil;
        logic next_nil;
        logic match;
        logic count_hit;    // count + 1 == position (walk target reached)
        logic pos_hit;      // count == position
        logic count_max;    // count + 1 == depth
        logic head_only;    // cur's link is null (the head's right after load)
        logic pos_zero;
        op_t  op;
    } dp_stat_t;

endpackage

>>> hw/rtl/all_datapath.sv
// node pool, free list pointers and walk registers
// depends on all_pkg
module all_datapath #(
    parameter int DEPTH = all_pkg::DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  all_pkg::dp_cmd_t cmd,
    output all_pkg::dp_stat_t stat,
    input  logic [2:0]       in_op,
    input  logic [31:0]      in_value,
    input  logic [5:0]       in_position,
    output logic [2:0]       res_status,
    output logic [31:0]      res_value,
    output logic [5:0]       res_fpos,
    output logic             res_last
);
    import all_pkg::*;

    localparam int AW = $clog2(DEPTH) + 1;   // extra bit marks null
    localparam int IW = $clog2(DEPTH);
    localparam logic [AW-1:0] NIL = {AW{1'b1}};

    logic [31:0]   values_mem [DEPTH];
    logic [AW-1:0] links_mem  [DEPTH];

    logic [AW-1:0] head_reg, free_reg, cur_reg, prev_reg, nxt_reg, newn_reg;
    logic [31:0]   val_rd_reg, v_reg;
    logic [5:0]    pos_reg;
    logic [6:0]    count_reg;
    op_t           op_reg;
    logic [IW-1:0] init_reg;
    logic          init_done_reg;
    logic [AW-1:0] free_link_reg;
    logic          splice_reg;
    logic [IW-1:0] splice_addr_reg;
    logic [AW-1:0] splice_link_reg;

    logic cur_ok;
    logic at_front;
    assign cur_ok   = (cur_reg != NIL);
    // positional insert at position zero behaves as insert at head
    assign at_front = (op_reg == OP_INS_POS) && (pos_reg == 6'd0);

    // memory port: one write per cycle
    logic          we;
    logic [IW-1:0] wa;
    logic [AW-1:0] wd;
    logic          vwe;
    logic [IW-1:0] vwa;
    logic [6:0]    depth_m1;
    assign depth_m1 = 7'(DEPTH - 1);

    always_comb
    begin
        we  = 1'b0;
        wa  = '0;
        wd  = NIL;
        vwe = 1'b0;
        vwa = newn_reg[IW-1:0];
        if (cmd.init_step)
        begin
            we = 1'b1;
            wa = init_reg;
            wd = (7'(init_reg) == depth_m1) ? NIL : AW'(init_reg) + AW'(1);
        end
        else if (cmd.do_update)
        begin
            case (op_reg)
                OP_INS_HEAD:
                begin
                    we = 1'b1; wa = newn_reg[IW-1:0]; wd = head_reg; vwe = 1'b1;
                end
                OP_INS_TAIL:
                begin
                    we = 1'b1; wa = newn_reg[IW-1:0]; wd = NIL; vwe = 1'b1;
                end
                OP_INS_POS:
                begin
                    we = 1'b1; wa = newn_reg[IW-1:0]; vwe = 1'b1;
                    wd = at_front ? head_reg : nxt_reg;
                end
                default:
                begin
                    // deletes push cur onto the free list
                    we = 1'b1; wa = cur_reg[IW-1:0]; wd = free_reg;
                end
            endcase
        end
    end

    // second link write (predecessor splice) lands the cycle after the update
    logic          we2;
    logic [IW-1:0] wa2;
    logic [AW-1:0] wd2;
    always_comb
    begin
        we2 = 1'b0;
        wa2 = cur_reg[IW-1:0];
        wd2 = newn_reg;
        if (cmd.do_update)
        begin
            case (op_reg)
                OP_INS_TAIL:
                begin
                    we2 = cur_ok; wa2 = cur_reg[IW-1:0]; wd2 = newn_reg;
                end
                OP_INS_POS:
                begin
                    we2 = cur_ok && !at_front; wa2 = cur_reg[IW-1:0]; wd2 = newn_reg;
                end
                OP_DEL_TAIL, OP_DEL_POS:
                begin
                    we2 = (prev_reg != NIL); wa2 = prev_reg[IW-1:0];
                    wd2 = (op_reg == OP_DEL_TAIL) ? NIL : nxt_reg;
                end
                default: we2 = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            links_mem[wa] <= wd;
        else if (splice_reg)
            links_mem[splice_addr_reg] <= splice_link_reg;
        if (vwe)
            values_mem[vwa] <= v_reg;
        if (cur_ok)
        begin
            val_rd_reg <= values_mem[cur_reg[IW-1:0]];
            nxt_reg    <= links_mem[cur_reg[IW-1:0]];
        end
        else
            nxt_reg <= NIL;
        if (free_reg != NIL)
            free_link_reg <= links_mem[free_reg[IW-1:0]];
        else
            free_link_reg <= NIL;
    end

    // walk pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= NIL;
            free_reg        <= '0;
            cur_reg         <= NIL;
            prev_reg        <= NIL;
            newn_reg        <= NIL;
            count_reg       <= '0;
            op_reg          <= OP_INS_HEAD;
            init_reg        <= '0;
            init_done_reg   <= 1'b0;
            splice_reg      <= 1'b0;
            splice_addr_reg <= '0;
            splice_link_reg <= NIL;
        end
        else
        begin
            splice_reg      <= we2;
            splice_addr_reg <= wa2;
            splice_link_reg <= wd2;
            if (cmd.init_step)
            begin
                init_reg <= init_reg + IW'(1);
                if (7'(init_reg) == depth_m1)
                    init_done_reg <= 1'b1;
            end
            if (cmd.load)
            begin
                op_reg    <= op_t'(in_op);
                cur_reg   <= head_reg;
                prev_reg  <= NIL;
                count_reg <= '0;
                newn_reg  <= free_reg;
            end
            if (cmd.advance)
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= nxt_reg;
                count_reg <= count_reg + 7'd1;
            end
            if (cmd.do_update)
            begin
                case (op_reg)
                    OP_INS_HEAD:
                    begin
                        head_reg <= newn_reg; free_reg <= free_link_reg;
                    end
                    OP_INS_TAIL, OP_INS_POS:
                    begin
                        free_reg <= free_link_reg;
                        if (!cur_ok || at_front)
                            head_reg <= newn_reg;
                    end
                    OP_DEL_HEAD:
                    begin
                        head_reg <= nxt_reg; free_reg <= cur_reg;
                    end
                    default:
                    begin
                        // removing the first node moves the head on
                        free_reg <= cur_reg;
                        if (prev_reg == NIL)
                            head_reg <= nxt_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg   <= in_value;
            pos_reg <= in_position;
        end
        if (cmd.set_res)
        begin
            res_status <= cmd.res_status;
            res_value  <= cmd.res_value ? val_rd_reg : 32'd0;
            res_fpos   <= cmd.res_fpos ? count_reg[5:0] : 6'd0;
            res_last   <= cmd.res_last;
        end
    end

    always_comb
    begin
        stat.init_done  = init_done_reg;
        stat.list_empty = (head_reg == NIL);
        stat.pool_full  = (free_reg == NIL);
        stat.cur_nil    = !cur_ok;
        stat.next_nil   = (nxt_reg == NIL);
        stat.match      = (val_rd_reg == v_reg);
        stat.count_hit  = ((count_reg + 7'd1) == {1'b0, pos_reg});
        stat.pos_hit    = (count_reg == {1'b0, pos_reg});
        stat.count_max  = ((count_reg + 7'd1) == 7'(DEPTH));
        stat.head_only  = (nxt_reg == NIL);
        stat.pos_zero   = (pos_reg == 6'd0);
        stat.op         = op_reg;
    end

endmodule

>>> hw/rtl/all_ctrl.sv
// request sequencer: walks the list and issues datapath commands
// depends on all_pkg
module all_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               res_taken,
    output logic               res_valid,
    input  all_pkg::dp_stat_t  stat,
    output all_pkg::dp_cmd_t   cmd
);
    import all_pkg::*;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign in_stall  = (state_reg != S_IDLE);

    task automatic emit(input status_t s, input logic v, input logic f, input logic l);
        cmd.set_res    = 1'b1;
        cmd.res_status = s;
        cmd.res_value  = v;
        cmd.res_fpos   = f;
        cmd.res_last   = l;
        res_valid_next = 1'b1;
    endtask

    always_comb
    begin
        logic free_out;
        free_out       = !res_valid_reg || res_taken;
        cmd            = '0;
        cmd.res_status = ST_OK;
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_taken;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_done)
                begin
                    cmd.init_step = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RDCUR;
                end
            end
            S_RDCUR:
            begin
                // link and value of cur become visible next cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
                case (stat.op)
                    OP_INS_HEAD:
                        if (!stat.pool_full) state_next = S_LINK;
                    OP_INS_TAIL:
                        if (!stat.pool_full)
                        begin
                            if (!stat.cur_nil && !stat.next_nil && !stat.count_max)
                            begin
                                cmd.advance = 1'b1; state_next = S_RDCUR;
                            end
                            else state_next = S_LINK;
                        end
                    OP_INS_POS:
                        if (!stat.pool_full)
                        begin
                            if (stat.pos_zero)
                                state_next = S_LINK;
                            else if (stat.cur_nil)
                                state_next = S_EMIT;
                            else if (!stat.count_hit)
                            begin
                                cmd.advance = 1'b1; state_next = S_RDCUR;
                            end
                            else state_next = S_LINK;
                        end
                    OP_DEL_HEAD:
                        if (!stat.list_empty) state_next = S_LINK;
                    OP_DEL_TAIL:
                        if (!stat.list_empty)
                        begin
                            if (!stat.next_nil && !stat.count_max)
                            begin
                                cmd.advance = 1'b1; state_next = S_RDCUR;
                            end
                            else state_next = S_LINK;
                        end
                    OP_DEL_POS:
                        if (!stat.list_empty)
                        begin
                            if (stat.cur_nil)
                                state_next = S_EMIT;
                            else if (!stat.pos_hit)
                            begin
                                cmd.advance = 1'b1; state_next = S_RDCUR;
                            end
                            else state_next = S_LINK;
                        end
                    OP_SEARCH:
                        if (!stat.cur_nil && !stat.match)
                        begin
                            if (!stat.count_max)
                            begin
                                cmd.advance = 1'b1; state_next = S_RDCUR;
                            end
                        end
                    default:
                        state_next = stat.list_empty ? S_EMIT : S_ROUT;
                endcase
            end
            S_LINK:
            begin
                if (free_out)
                begin
                    cmd.do_update = 1'b1;
                    emit(ST_OK, 1'b0, 1'b0, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (free_out)
                begin
                    state_next = S_IDLE;
                    case (stat.op)
                        OP_INS_HEAD, OP_INS_TAIL:
                            emit(ST_FULL, 1'b0, 1'b0, 1'b1);
                        OP_INS_POS:
                            emit(stat.pool_full ? ST_FULL : ST_RANGE, 1'b0, 1'b0, 1'b1);
                        OP_DEL_HEAD, OP_DEL_TAIL:
                            emit(ST_EMPTY, 1'b0, 1'b0, 1'b1);
                        OP_DEL_POS:
                            emit(stat.list_empty ? ST_EMPTY : ST_RANGE, 1'b0, 1'b0, 1'b1);
                        OP_SEARCH:
                            if (!stat.cur_nil && stat.match)
                                emit(ST_OK, 1'b0, 1'b1, 1'b1);
                            else
                                emit(ST_NFND, 1'b0, 1'b0, 1'b1);
                        default:
                            emit(ST_EMPTY, 1'b0, 1'b0, 1'b1);
                    endcase
                end
            end
            S_ROUT:
            begin
                // value and link of cur are valid here
                if (free_out)
                begin
                    if (stat.next_nil || stat.count_max)
                    begin
                        emit(ST_OK, 1'b1, 1'b0, 1'b1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit(ST_OK, 1'b1, 1'b0, 1'b0);
                        cmd.advance = 1'b1;
                        state_next  = S_WALK;
                    end
                end
            end
            S_WALK:
                state_next = S_ROUT;
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/array_linked_list_engine.sv
// top level of the array linked list engine: controller plus node pool datapath
// depends on all_pkg, all_ctrl, all_datapath
//
// channel   direction  handshake           payload
// request   in         valid / stall       op, item_value, position
// result    out        res_valid/res_stall status, out_value, found_position, last
//
// a request walks the node pool link by link, each link taking one read of
// the link memory (S_RDCUR) and one decide step (S_DECIDE); a readout
// alternates emitting an element (S_ROUT) with a step to the next (S_WALK).
// after reset a sweep over all DEPTH nodes writes the free chain; requests stall meanwhile.
// the result register holds while res_stall is high and the walk waits on it.
module array_linked_list_engine #(
    parameter int DEPTH = all_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [2:0]  op,
    input  logic signed [31:0] item_value,
    input  logic [5:0]  position,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  status,
    output logic signed [31:0] out_value,
    output logic [5:0]  found_position,
    output logic        last
);
    import all_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     taken;
    logic [31:0] value_u;

    assign taken = res_valid && !res_stall;

    all_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid),
        .in_stall  (stall),
        .res_taken (taken),
        .res_valid (res_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    all_datapath #(.DEPTH(DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_op       (op),
        .in_value    (item_value),
        .in_position (position),
        .res_status  (status),
        .res_value   (value_u),
        .res_fpos    (found_position),
        .res_last    (last)
    );

    assign out_value = value_u;

    // a result is only overwritten once taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(out_value))
        else $error("result changed while stalled");

    // a request is never accepted while a walk is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !$past(cmd.advance) && !cmd.do_update)
        else $error("request loaded during a walk");

    // the pool is never both full and empty of list nodes
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_done |-> !(stat.pool_full && stat.list_empty))
        else $error("pool bookkeeping lost a node");

endmodule

>>> verif/array_linked_list_engine_test.sv
// testbench for array_linked_list_engine: directed and random list requests
// depends on all_pkg and the array_linked_list_engine rtl
`timescale 1ns / 100ps

module array_linked_list_engine_test;
    import all_pkg::*;

    localparam int NODES     = 16;
    localparam int NIL       = 255;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        op_t         op;
        logic [31:0] item_value;
        logic [5:0]  position;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_value;
        logic [5:0]  found_position;
        logic        last;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        stall;
    logic [2:0]  op = '0;
    logic signed [31:0] item_value = '0;
    logic [5:0]  position = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [2:0]  status;
    logic signed [31:0] out_value;
    logic [5:0]  found_position;
    logic        last;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_cycles = 0;
    int       errors = 0;
    int       answers_seen = 0;
    int       cycles = 0;
    int       requests_sent = 0;
    bit       timed_out = 1'b0;
    bit       taken_in = 1'b0;

    // shadow of the node pool
    logic [31:0] pool_val[NODES];
    int          pool_link[NODES];
    int          head_idx;
    int          free_idx;

    array_linked_list_engine u_top (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall), .op(op),
        .item_value(item_value), .position(position), .res_valid(res_valid),
        .res_stall(res_stall), .status(status), .out_value(out_value),
        .found_position(found_position), .last(last)
    );

    always #5 clk = ~clk;

    function automatic int next_node(int n);
        if (n >= NODES)
            return NIL;
        return pool_link[n];
    endfunction

    function automatic int take_node();
        int n;
        n = free_idx;
        if (n >= NODES)
            return NIL;
        free_idx = pool_link[n];
        return n;
    endfunction

    function automatic void return_node(int n);
        if (n < NODES)
        begin
            pool_link[n] = free_idx;
            free_idx = n;
        end
    endfunction

    function automatic void push_answer(status_t st, logic [31:0] v, int fp, bit lst);
        answer_t a;
        a.status = st;
        a.out_value = v;
        a.found_position = fp[5:0];
        a.last = lst;
        expected_answers.push_back(a);
    endfunction

    function automatic void list_reset();
        for (int i = 0; i < NODES; i++)
        begin
            pool_val[i] = '0;
            pool_link[i] = (i == NODES - 1) ? NIL : i + 1;
        end
        head_idx = NIL;
        free_idx = 0;
    endfunction

    function automatic status_t push_front(logic [31:0] v);
        int n;
        n = take_node();
        if (n == NIL)
            return ST_FULL;
        pool_val[n] = v;
        pool_link[n] = head_idx;
        head_idx = n;
        return ST_OK;
    endfunction

    function automatic status_t pop_front();
        int n;
        n = head_idx;
        if (n >= NODES)
            return ST_EMPTY;
        head_idx = pool_link[n];
        return_node(n);
        return ST_OK;
    endfunction

    // predict the answers for one request and update the shadow list
    function automatic void apply_list_request(request_t r);
        status_t st;
        int n, cur, prev, fp, k, nx;
        st = ST_OK;
        fp = 0;
        case (r.op)
            OP_INS_HEAD: st = push_front(r.item_value);
            OP_INS_TAIL:
            begin
                n = take_node();
                if (n == NIL)
                    st = ST_FULL;
                else
                begin
                    pool_val[n] = r.item_value;
                    pool_link[n] = NIL;
                    if (head_idx >= NODES)
                        head_idx = n;
                    else
                    begin
                        cur = head_idx;
                        while (next_node(cur) != NIL)
                            cur = next_node(cur);
                        pool_link[cur] = n;
                    end
                end
            end
            OP_INS_POS:
            begin
                if (r.position == 0)
                    st = push_front(r.item_value);
                else
                begin
                    n = take_node();
                    if (n == NIL)
                        st = ST_FULL;
                    else
                    begin
                        cur = head_idx;
                        for (int i = 0; i + 1 < r.position && cur != NIL; i++)
                            cur = next_node(cur);
                        if (cur >= NODES)
                        begin
                            return_node(n);
                            st = ST_RANGE;
                        end
                        else
                        begin
                            pool_val[n] = r.item_value;
                            pool_link[n] = pool_link[cur];
                            pool_link[cur] = n;
                        end
                    end
                end
            end
            OP_DEL_HEAD: st = pop_front();
            OP_DEL_TAIL:
            begin
                if (head_idx >= NODES)
                    st = ST_EMPTY;
                else if (next_node(head_idx) == NIL)
                    st = pop_front();
                else
                begin
                    prev = head_idx;
                    cur = next_node(head_idx);
                    while (next_node(cur) != NIL)
                    begin
                        prev = cur;
                        cur = next_node(cur);
                    end
                    pool_link[prev] = NIL;
                    return_node(cur);
                end
            end
            OP_DEL_POS:
            begin
                if (head_idx >= NODES)
                    st = ST_EMPTY;
                else if (r.position == 0)
                    st = pop_front();
                else
                begin
                    prev = NIL;
                    cur = head_idx;
                    for (int i = 0; i < r.position && cur != NIL; i++)
                    begin
                        prev = cur;
                        cur = next_node(cur);
                    end
                    if (cur >= NODES || prev >= NODES)
                        st = ST_RANGE;
                    else
                    begin
                        pool_link[prev] = pool_link[cur];
                        return_node(cur);
                    end
                end
            end
            OP_SEARCH:
            begin
                st = ST_NFND;
                cur = head_idx;
                for (int i = 0; i < NODES && cur < NODES; i++)
                begin
                    if (pool_val[cur] == r.item_value)
                    begin
                        st = ST_OK;
                        fp = i;
                        break;
                    end
                    cur = pool_link[cur];
                end
            end
            default:
            begin
                if (head_idx >= NODES)
                    st = ST_EMPTY;
                else
                begin
                    cur = head_idx;
                    k = 0;
                    while (k < NODES && cur < NODES)
                    begin
                        nx = pool_link[cur];
                        push_answer(ST_OK, pool_val[cur], 0,
                                    (nx >= NODES) || (k + 1 >= NODES));
                        k++;
                        cur = nx;
                    end
                    return;
                end
            end
        endcase
        push_answer(st, '0, fp, 1'b1);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at answer %0d: %s got %0h expected %0h",
                 answers_seen, what, got, want);
    endtask

    // sender: new transaction at the falling edge once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!valid || taken_in))
        begin
            if (taken_in)
                requests_sent++;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                request_t r;
                r = pending_reqs.pop_front();
                valid <= 1'b1;
                op <= r.op;
                item_value <= r.item_value;
                position <= r.position;
            end
            else
                valid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // prediction at acceptance, checking of results
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        taken_in <= rst_n && valid && !stall;
        if (rst_n && valid && !stall)
        begin
            request_t r;
            r.op = op_t'(op);
            r.item_value = item_value;
            r.position = position;
            apply_list_request(r);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            answers_seen++;
            if (expected_answers.size() == 0)
                report_mismatch("unexpected result, status", 32'(status), 32'd0);
            else
            begin
                answer_t w;
                w = expected_answers.pop_front();
                if (status !== w.status)
                    report_mismatch("status", 32'(status), 32'(w.status));
                if (out_value !== w.out_value)
                    report_mismatch("out_value", out_value, w.out_value);
                if (found_position !== w.found_position)
                    report_mismatch("found_position", 32'(found_position),
                                    32'(w.found_position));
                if (last !== w.last)
                    report_mismatch("last", 32'(last), 32'(w.last));
            end
        end
    end

    function automatic request_t make_req(op_t o, logic [31:0] v, int p);
        request_t r;
        r.op = o;
        r.item_value = v;
        r.position = p[5:0];
        return r;
    endfunction

    // random request biased towards short positions and a small value set
    function automatic request_t random_req();
        int w;
        logic [31:0] v;
        w = $urandom_range(99);
        v = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
        if (w < 45)
            return make_req(op_t'($urandom_range(2)), v,
                            ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(17));
        if (w < 75)
            return make_req(op_t'($urandom_range(5, 3)), v,
                            ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(17));
        if (w < 90)
            return make_req(OP_SEARCH, v, $urandom_range(63));
        return make_req(OP_READOUT, v, $urandom_range(63));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || valid || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        list_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, full pool, extremes, every op
        pending_reqs.push_back(make_req(OP_READOUT, '0, 0));
        pending_reqs.push_back(make_req(OP_DEL_HEAD, '0, 0));
        pending_reqs.push_back(make_req(OP_DEL_TAIL, '0, 0));
        pending_reqs.push_back(make_req(OP_DEL_POS, '0, 63));
        pending_reqs.push_back(make_req(OP_SEARCH, 32'h7fffffff, 0));
        pending_reqs.push_back(make_req(OP_INS_POS, 32'h80000000, 1));
        pending_reqs.push_back(make_req(OP_INS_POS, 32'h80000000, 0));
        pending_reqs.push_back(make_req(OP_INS_TAIL, 32'h7fffffff, 0));
        pending_reqs.push_back(make_req(OP_INS_POS, 32'hffffffff, 2));
        pending_reqs.push_back(make_req(OP_INS_POS, 32'h0, 63));
        for (int i = 0; i < 14; i++)
            pending_reqs.push_back(make_req(OP_INS_HEAD, i * 32'h11111111, 0));
        pending_reqs.push_back(make_req(OP_INS_TAIL, 1, 0));
        pending_reqs.push_back(make_req(OP_INS_POS, 2, 0));
        pending_reqs.push_back(make_req(OP_SEARCH, 32'hffffffff, 0));
        pending_reqs.push_back(make_req(OP_READOUT, 0, 63));
        pending_reqs.push_back(make_req(OP_DEL_POS, 0, 16));
        pending_reqs.push_back(make_req(OP_DEL_POS, 0, 15));
        pending_reqs.push_back(make_req(OP_DEL_TAIL, 0, 0));
        pending_reqs.push_back(make_req(OP_DEL_POS, 0, 5));
        send_idle_pct = 9;
        recv_idle_pct = 47;
        wait_drained();

        // sender pauses until everything has come back, then long receiver hold
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(random_req());
        @(negedge clk);
        hold_cycles = 300;
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 9 : 0;
            for (int i = 0; i < 115; i++)
                pending_reqs.push_back(random_req());
            wait_drained();
        end
        repeat (80) @(posedge clk);

        $display("sent %0d requests of all eight kinds, checked %0d results",
                 requests_sent, answers_seen);
        $display("covered empty, full, range and search-miss cases plus back-pressure");
        if (errors == 0)
            $display("** array_linked_list_engine: PASSED **");
        else
            $display("** array_linked_list_engine: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > CYC_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("timeout after %0d cycles", cycles);
            $display("** array_linked_list_engine: FAILED **");
            $finish;
        end
    end

endmodule
